// File: hw/rtl/chlp_pkg.sv
// shared types and constants for the commit header line parser
`timescale 1ns / 1ps
`default_nettype none

package chlp_pkg;

  localparam logic [7:0] NL = 8'h0A;
  localparam logic [7:0] SP = 8'h20;

  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int MaxRes = 3;

  typedef enum logic [2:0] {
    ROLE_FIELD  = 3'd0,
    ROLE_FEND   = 3'd1,
    ROLE_VALUE  = 3'd2,
    ROLE_HEND   = 3'd3,
    ROLE_BSTART = 3'd4,
    ROLE_BODY   = 3'd5,
    ROLE_ERR    = 3'd6
  } role_e;

  typedef struct packed {
    role_e      role;
    logic [7:0] data;
  } res_t;

  // all results caused by one input beat
  typedef struct packed {
    logic [1:0]              cnt;
    res_t [MaxRes-1:0]       res;
    logic                    done;
  } bundle_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

`default_nettype wire

// File: hw/rtl/chlp_front.sv
// front end: phase tracking and classification of each input byte
`timescale 1ns / 1ps
`default_nettype none

module chlp_front import chlp_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       accept_i,
  input  wire logic [7:0] data_byte_i,
  input  wire logic       object_last_i,
  output bundle_t         bnd_o,
  output logic            push_o
);

  typedef enum logic [5:0] {
    PH_LINE  = 6'b000001,
    PH_FIELD = 6'b000010,
    PH_VALUE = 6'b000100,
    PH_HELD  = 6'b001000,
    PH_BODY  = 6'b010000,
    PH_DROP  = 6'b100000
  } phase_e;

  phase_e phase_q, phase_d;

  always_comb begin
    logic [1:0] n;
    logic       start;
    logic       err;
    bundle_t    b;
    phase_e     nxt;
    n     = 2'd0;
    start = 1'b0;
    err   = 1'b0;
    b     = '0;
    nxt   = phase_q;
    case (phase_q)
      PH_FIELD: begin
        if (data_byte_i == NL) begin
          b.res[n] = '{ROLE_ERR, 8'h00}; n = n + 2'd1;
          nxt = PH_DROP;
          err = 1'b1;
        end else if (data_byte_i == SP) begin
          b.res[n] = '{ROLE_FEND, SP}; n = n + 2'd1;
          nxt = PH_VALUE;
          if (object_last_i) begin
            b.res[n] = '{ROLE_HEND, 8'h00}; n = n + 2'd1;
          end
        end else begin
          b.res[n] = '{ROLE_FIELD, data_byte_i}; n = n + 2'd1;
          if (object_last_i) begin
            b.res[n] = '{ROLE_ERR, 8'h00}; n = n + 2'd1;
          end
        end
      end
      PH_VALUE: begin
        if (data_byte_i == NL) begin
          nxt = PH_HELD;
        end else begin
          b.res[n] = '{ROLE_VALUE, data_byte_i}; n = n + 2'd1;
        end
        if (object_last_i) begin
          b.res[n] = '{ROLE_HEND, 8'h00}; n = n + 2'd1;
        end
      end
      PH_HELD: begin
        if (data_byte_i == SP) begin
          b.res[n] = '{ROLE_VALUE, NL}; n = n + 2'd1;
          b.res[n] = '{ROLE_VALUE, SP}; n = n + 2'd1;
          nxt = PH_VALUE;
          if (object_last_i) begin
            b.res[n] = '{ROLE_HEND, 8'h00}; n = n + 2'd1;
          end
        end else begin
          b.res[n] = '{ROLE_HEND, 8'h00}; n = n + 2'd1;
          start = 1'b1;
        end
      end
      PH_BODY: begin
        b.res[n] = '{ROLE_BODY, data_byte_i}; n = n + 2'd1;
      end
      PH_DROP: begin
        nxt = PH_DROP;
      end
      default: begin
        start = 1'b1;
      end
    endcase

    // first byte of a line
    if (start) begin
      if (data_byte_i == NL) begin
        b.res[n] = '{ROLE_BSTART, 8'h00}; n = n + 2'd1;
        nxt = PH_BODY;
      end else if (data_byte_i == SP) begin
        b.res[n] = '{ROLE_FEND, SP}; n = n + 2'd1;
        nxt = PH_VALUE;
        if (object_last_i) begin
          b.res[n] = '{ROLE_HEND, 8'h00}; n = n + 2'd1;
        end
      end else begin
        b.res[n] = '{ROLE_FIELD, data_byte_i}; n = n + 2'd1;
        nxt = PH_FIELD;
        if (object_last_i) begin
          b.res[n] = '{ROLE_ERR, 8'h00}; n = n + 2'd1;
        end
      end
    end

    if (object_last_i) begin
      nxt = PH_LINE;
    end
    b.cnt  = n;
    b.done = object_last_i | err;
    bnd_o  = b;
    push_o = accept_i && (n != 2'd0);
    phase_d = accept_i ? nxt : phase_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_LINE;
    end else begin
      phase_q <= phase_d;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/chlp_queue.sv
// short queue of result bundles between front and back end
`timescale 1ns / 1ps
`default_nettype none

module chlp_queue import chlp_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    push_i,
  input  wire bundle_t bnd_i,
  input  wire logic    pop_i,
  output bundle_t      head_o,
  output qstat_t       stat_o
);

  bundle_t            mem_q [QDepth];
  logic [QPtrW-1:0]   wptr_q, wptr_d, rptr_q, rptr_d;
  logic [QPtrW:0]     cnt_q, cnt_d;

  always_comb begin
    wptr_d = push_i ? wptr_q + 1'b1 : wptr_q;
    rptr_d = pop_i ? rptr_q + 1'b1 : rptr_q;
    cnt_d  = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= bnd_i;
    end
  end

  assign head_o       = mem_q[rptr_q];
  assign stat_o.full  = (cnt_q == (QPtrW+1)'(QDepth));
  assign stat_o.empty = (cnt_q == '0);

endmodule

`default_nettype wire

// File: hw/rtl/chlp_back.sv
// back end: walks a bundle one result per cycle into the output register, while the receiver takes the results
`timescale 1ns / 1ps
`default_nettype none

module chlp_back import chlp_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire bundle_t head_i,
  input  wire qstat_t  stat_i,
  output logic         pop_o,
  output logic         out_valid_o,
  input  wire logic    out_ready_i,
  output logic [2:0]   role_o,
  output logic [7:0]   out_byte_o,
  output logic         run_last_o,
  output logic         object_done_o
);

  logic [1:0] idx_q, idx_d;
  logic       vld_q, vld_d;
  role_e      role_q, role_d;
  logic [7:0] byte_q, byte_d;
  logic       rl_q, rl_d;
  logic       od_q, od_d;
  logic       load;
  logic       final_res;

  assign load      = (!vld_q || out_ready_i) && !stat_i.empty;
  assign final_res = (idx_q == head_i.cnt - 2'd1);
  assign pop_o     = load && final_res;

  always_comb begin
    idx_d  = idx_q;
    vld_d  = vld_q;
    role_d = role_q;
    byte_d = byte_q;
    rl_d   = rl_q;
    od_d   = od_q;
    if (load) begin
      vld_d  = 1'b1;
      role_d = head_i.res[idx_q].role;
      byte_d = head_i.res[idx_q].data;
      rl_d   = final_res;
      od_d   = final_res && head_i.done;
      idx_d  = final_res ? 2'd0 : idx_q + 2'd1;
    end else if (out_ready_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= 2'd0;
      vld_q <= 1'b0;
    end else begin
      idx_q <= idx_d;
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    role_q <= role_d;
    byte_q <= byte_d;
    rl_q   <= rl_d;
    od_q   <= od_d;
  end

  assign out_valid_o   = vld_q;
  assign role_o        = role_q;
  assign out_byte_o    = byte_q;
  assign run_last_o    = rl_q;
  assign object_done_o = od_q;

endmodule

`default_nettype wire

// File: hw/rtl/commit_header_line_parser_unit.sv
// top level of the commit header line parser
// path: an accepted input beat is written to the bundle queue, then its results are loaded into the output register
// throughput: one input beat per cycle while each byte gives at most one result and
//   the receiver does not stall; a byte giving k results holds the output stage while
//   they leave the single result register one by one; a four-entry bundle queue absorbs such bursts
// reset: phase returns to line start, queue empties, output goes invalid
`timescale 1ns / 1ps
`default_nettype none

module commit_header_line_parser_unit import chlp_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] data_byte_i,
  input  wire logic       object_last_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [2:0]      role_o,
  output logic [7:0]      out_byte_o,
  output logic            run_last_o,
  output logic            object_done_o
);

  bundle_t bnd;
  bundle_t head;
  qstat_t  stat;
  logic    push;
  logic    pop;
  logic    accept;

  assign in_ready_o = !stat.full;
  assign accept     = in_valid_i && in_ready_o;

  chlp_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .data_byte_i   (data_byte_i),
    .object_last_i (object_last_i),
    .bnd_o         (bnd),
    .push_o        (push)
  );

  chlp_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .bnd_i  (bnd),
    .pop_i  (pop),
    .head_o (head),
    .stat_o (stat)
  );

  chlp_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head),
    .stat_i        (stat),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .role_o        (role_o),
    .out_byte_o    (out_byte_o),
    .run_last_o    (run_last_o),
    .object_done_o (object_done_o)
  );

endmodule

`default_nettype wire

// File: hw/rtl/chlp_checker.sv
// port-level checks on the parser output, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module chlp_checker import chlp_pkg::*; (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       out_valid_o,
  input wire logic       out_ready_i,
  input wire logic [2:0] role_o,
  input wire logic [7:0] out_byte_o,
  input wire logic       run_last_o,
  input wire logic       object_done_o
);

  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output beat dropped while stalled");

  a_hold_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(role_o) && $stable(out_byte_o))
    else $error("output payload changed while stalled");

  a_role_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> role_o != 3'd7)
    else $error("undefined role code");

  a_mark_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (role_o == ROLE_HEND || role_o == ROLE_BSTART || role_o == ROLE_ERR)
    |-> out_byte_o == 8'h00)
    else $error("mark beat carries a byte");

  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && object_done_o |-> run_last_o)
    else $error("object end not on last beat of its input");

endmodule

bind commit_header_line_parser_unit chlp_checker u_chlp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .role_o        (role_o),
  .out_byte_o    (out_byte_o),
  .run_last_o    (run_last_o),
  .object_done_o (object_done_o)
);

`default_nettype wire

// File: test/tb.sv
// testbench for the commit header line parser: directed table, random objects, scoreboard
`timescale 1ns / 1ps

module tb;
  import chlp_pkg::*;

  localparam int RandItems  = 245;
  localparam int CycleLimit = 200000;

  typedef enum logic [2:0] {
    ST_LINE  = 3'd0,
    ST_FIELD = 3'd1,
    ST_VALUE = 3'd2,
    ST_HELD  = 3'd3,
    ST_BODY  = 3'd4,
    ST_DROP  = 3'd5
  } parse_state_e;

  typedef struct packed {
    role_e      role;
    logic [7:0] data;
    logic       run_last;
    logic       done;
  } beat_t;

  // one input beat; typed rows carry their own expected beats
  typedef struct packed {
    logic [7:0]  b;
    logic        last;
    logic        typed;
    logic [1:0]  n;
    beat_t [2:0] want;
  } row_t;

  localparam beat_t NoBeat = '0;

  logic       clk_i         = 1'b0;
  logic       rst_ni        = 1'b0;
  logic       in_valid_i    = 1'b0;
  logic       in_ready_o;
  logic [7:0] data_byte_i   = 8'h00;
  logic       object_last_i = 1'b0;
  logic       out_valid_o;
  logic       out_ready_i   = 1'b1;
  logic [2:0] role_o;
  logic [7:0] out_byte_o;
  logic       run_last_o;
  logic       object_done_o;

  row_t         stim_q [$];
  row_t         cur_row = '0;
  beat_t        expected_beats [$];
  parse_state_e parse_state = ST_LINE;
  beat_t        pred_buf [3];
  int           pred_n;
  int           err_cnt = 0;
  int           res_cnt = 0;
  int           rx_cnt  = 0;
  int           rx_hold = 0;
  int           cycles  = 0;

  commit_header_line_parser_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .data_byte_i   (data_byte_i),
    .object_last_i (object_last_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .role_o        (role_o),
    .out_byte_o    (out_byte_o),
    .run_last_o    (run_last_o),
    .object_done_o (object_done_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic beat_t bt(role_e r, logic [7:0] d, logic rl, logic dn);
    beat_t x;
    x.role     = r;
    x.data     = d;
    x.run_last = rl;
    x.done     = dn;
    return x;
  endfunction

  function automatic void add_beat(role_e r, logic [7:0] d);
    pred_buf[pred_n] = bt(r, d, 1'b0, 1'b0);
    pred_n++;
  endfunction

  function automatic void open_line(logic [7:0] b, logic last);
    if (b == NL) begin
      add_beat(ROLE_BSTART, 8'h00);
      parse_state = ST_BODY;
    end else if (b == SP) begin
      add_beat(ROLE_FEND, SP);
      parse_state = ST_VALUE;
      if (last) add_beat(ROLE_HEND, 8'h00);
    end else begin
      add_beat(ROLE_FIELD, b);
      parse_state = ST_FIELD;
      if (last) add_beat(ROLE_ERR, 8'h00);
    end
  endfunction

  // works out the beats one input byte gives and moves the parse state on
  function automatic void parse_byte(logic [7:0] b, logic last);
    logic err_end;
    err_end = 1'b0;
    pred_n  = 0;
    case (parse_state)
      ST_FIELD: begin
        if (b == NL) begin
          add_beat(ROLE_ERR, 8'h00);
          parse_state = ST_DROP;
          err_end = 1'b1;
        end else if (b == SP) begin
          add_beat(ROLE_FEND, SP);
          parse_state = ST_VALUE;
          if (last) add_beat(ROLE_HEND, 8'h00);
        end else begin
          add_beat(ROLE_FIELD, b);
          if (last) add_beat(ROLE_ERR, 8'h00);
        end
      end
      ST_VALUE: begin
        if (b == NL) begin
          parse_state = ST_HELD;
        end else begin
          add_beat(ROLE_VALUE, b);
        end
        if (last) add_beat(ROLE_HEND, 8'h00);
      end
      ST_HELD: begin
        if (b == SP) begin
          add_beat(ROLE_VALUE, NL);
          add_beat(ROLE_VALUE, SP);
          parse_state = ST_VALUE;
          if (last) add_beat(ROLE_HEND, 8'h00);
        end else begin
          add_beat(ROLE_HEND, 8'h00);
          open_line(b, last);
        end
      end
      ST_BODY: begin
        add_beat(ROLE_BODY, b);
      end
      ST_DROP: begin
      end
      default: begin
        open_line(b, last);
      end
    endcase
    if (pred_n > 0) begin
      pred_buf[pred_n-1].run_last = 1'b1;
      if (last || err_end) pred_buf[pred_n-1].done = 1'b1;
    end
    if (last) parse_state = ST_LINE;
  endfunction

  task automatic add_row(logic [7:0] b, logic last, logic typed, logic [1:0] n,
                         beat_t w0, beat_t w1, beat_t w2);
    row_t r;
    r.b     = b;
    r.last  = last;
    r.typed = typed;
    r.n     = n;
    r.want  = {w2, w1, w0};
    stim_q.push_back(r);
  endtask

  task automatic add_plain(logic [7:0] b, logic last);
    add_row(b, last, 1'b0, 2'd0, NoBeat, NoBeat, NoBeat);
  endtask

  function automatic logic [7:0] plain_byte();
    logic [7:0] v;
    do v = 8'($urandom_range(0, 255)); while (v == NL || v == SP);
    return v;
  endfunction

  // mostly well-formed header objects, some cut short or broken, some noise
  task automatic gen_object();
    logic [7:0] obj [$];
    logic [7:0] v;
    int kind;
    int lines;
    int len;
    int cut;
    kind = $urandom_range(0, 9);
    if (kind >= 8) begin
      len = $urandom_range(1, 10);
      repeat (len) begin
        case ($urandom_range(0, 3))
          0: obj.push_back(NL);
          1: obj.push_back(SP);
          default: obj.push_back(8'($urandom_range(0, 255)));
        endcase
      end
    end else begin
      lines = $urandom_range(0, 3);
      repeat (lines) begin
        len = $urandom_range(0, 4);
        repeat (len) obj.push_back(plain_byte());
        obj.push_back(SP);
        len = $urandom_range(0, 5);
        repeat (len) begin
          if ($urandom_range(0, 5) == 0) begin
            obj.push_back(NL);
            obj.push_back(SP);
          end else begin
            do v = 8'($urandom_range(0, 255)); while (v == NL);
            obj.push_back(v);
          end
        end
        obj.push_back(NL);
      end
      if ($urandom_range(0, 1) == 1) begin
        obj.push_back(NL);
        len = $urandom_range(0, 6);
        repeat (len) obj.push_back(8'($urandom_range(0, 255)));
      end
      if (obj.size() == 0) obj.push_back(plain_byte());
      if (kind == 7) begin
        if ($urandom_range(0, 1) == 1) begin
          cut = $urandom_range(1, obj.size());
          while (obj.size() > cut) void'(obj.pop_back());
        end else begin
          obj.insert($urandom_range(0, obj.size() - 1), NL);
        end
      end
    end
    foreach (obj[i]) add_plain(obj[i], i == obj.size() - 1);
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    if (err_cnt < 40)
      $display("result %0d: %s got %0d expected %0d", res_cnt, what, got, want);
    err_cnt++;
  endtask

  // scoreboard: predict on every accepted input beat, check every accepted result beat
  always @(posedge clk_i) begin
    beat_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        parse_byte(data_byte_i, object_last_i);
        if (cur_row.typed) begin
          for (int k = 0; k < cur_row.n; k++) expected_beats.push_back(cur_row.want[k]);
        end else begin
          for (int k = 0; k < pred_n; k++) expected_beats.push_back(pred_buf[k]);
        end
      end
      if (out_valid_o && out_ready_i) begin
        res_cnt++;
        if (expected_beats.size() == 0) begin
          report_mismatch("unexpected beat, role", role_o, -1);
        end else begin
          want = expected_beats.pop_front();
          if (role_o != want.role) report_mismatch("role", role_o, want.role);
          if (out_byte_o != want.data) report_mismatch("out_byte", out_byte_o, want.data);
          if (run_last_o != want.run_last)
            report_mismatch("run_last", run_last_o, want.run_last);
          if (object_done_o != want.done)
            report_mismatch("object_done", object_done_o, want.done);
        end
      end
    end
  end

  // receiver stalls
  always @(posedge clk_i) begin
    int w;
    if (rx_hold > 0) begin
      rx_hold <= rx_hold - 1;
      if (rx_hold == 1) out_ready_i <= 1'b1;
    end else if (rst_ni && out_valid_o && out_ready_i) begin
      rx_cnt++;
      w = ((rx_cnt / 50) % 3 == 1) ? 0 : $urandom_range(0, 10);
      if (w != 0) begin
        out_ready_i <= 1'b0;
        rx_hold     <= w;
      end
    end
  end

  initial begin
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    int n_dir;
    int gap;
    logic pause;
    row_t r;

    // after reset, extremes, error codes
    add_row(8'h00, 1'b0, 1'b1, 2'd1, bt(ROLE_FIELD, 8'h00, 1'b1, 1'b0), NoBeat, NoBeat);
    add_row(NL, 1'b0, 1'b1, 2'd1, bt(ROLE_ERR, 8'h00, 1'b1, 1'b1), NoBeat, NoBeat);
    add_row(8'hFF, 1'b1, 1'b1, 2'd0, NoBeat, NoBeat, NoBeat);
    add_row(SP, 1'b1, 1'b1, 2'd2, bt(ROLE_FEND, SP, 1'b0, 1'b0),
            bt(ROLE_HEND, 8'h00, 1'b1, 1'b1), NoBeat);
    add_row(8'hFF, 1'b0, 1'b1, 2'd1, bt(ROLE_FIELD, 8'hFF, 1'b1, 1'b0), NoBeat, NoBeat);
    add_row(8'h61, 1'b1, 1'b1, 2'd2, bt(ROLE_FIELD, 8'h61, 1'b0, 1'b0),
            bt(ROLE_ERR, 8'h00, 1'b1, 1'b1), NoBeat);
    // folded value, header end, body start, body bytes
    add_plain("a", 1'b0);
    add_plain("b", 1'b0);
    add_plain(SP, 1'b0);
    add_plain("c", 1'b0);
    add_plain("d", 1'b0);
    add_plain(NL, 1'b0);
    add_plain(SP, 1'b0);
    add_plain("e", 1'b0);
    add_plain(NL, 1'b0);
    add_plain("x", 1'b0);
    add_plain(SP, 1'b0);
    add_plain("y", 1'b0);
    add_plain(NL, 1'b0);
    add_plain(NL, 1'b0);
    add_plain("B", 1'b0);
    add_plain(8'hFF, 1'b1);
    // object ends on a held newline
    add_plain("k", 1'b0);
    add_plain(SP, 1'b0);
    add_plain(NL, 1'b1);
    n_dir = stim_q.size();
    while (stim_q.size() < n_dir + RandItems) gen_object();

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (stim_q[idx]) begin
      r     = stim_q[idx];
      pause = (idx == n_dir) || (idx == n_dir + RandItems / 2);
      gap   = ((idx / 37) % 4 == 3) ? 0 : $urandom_range(0, 10);
      if (gap > 0 || pause) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
        if (pause) begin
          // hold off until the block has drained
          @(posedge clk_i);
          while (expected_beats.size() != 0) @(posedge clk_i);
        end
      end
      in_valid_i    <= 1'b1;
      data_byte_i   <= r.b;
      object_last_i <= r.last;
      cur_row       <= r;
      @(posedge clk_i);
      while (!in_ready_o) @(posedge clk_i);
    end
    in_valid_i <= 1'b0;

    @(posedge clk_i);
    while (expected_beats.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    if (err_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
